// ----- rtl/sorted_unique_key_table_defines.svh -----
// Assertion macros shared by the sorted unique key table RTL
`ifndef SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH

// Check that cond holds at every clock edge outside reset.
`define SUK_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Check that cons holds in the cycle where ante holds.
`define SUK_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define SUK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/suk_pkg.sv -----
// Types and constants for the sorted unique key table
package suk_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_W     = 64;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 3;
    localparam int POS_W     = 6;
    localparam int COUNT_W   = 7;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    // Flip the sign bit so that unsigned order matches signed order.
    localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [KEY_W-1:0] key;
    } suk_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } suk_out_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             cmp_en;
        logic             ins_en;
        logic [KEY_W-1:0] key;
    } suk_ctrl_t;

endpackage

// ----- rtl/suk_cell.sv -----
// One slot of the sorted key row: compare, then hold, load or shift up
module suk_cell
    import suk_pkg::*;
(
    input  logic             aclk,
    input  suk_ctrl_t        ctrl,
    input  logic             occupied,
    input  logic             prev_lt,
    input  logic [KEY_W-1:0] prev_key,
    output logic [KEY_W-1:0] key_out,
    output logic             lt_out,
    output logic             eq_out,
    output logic             at_here
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             lt_reg;
    logic             lt_next;
    logic             eq_reg;
    logic             eq_next;

    assign at_here = !lt_reg && prev_lt;

    always_comb begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctrl.cmp_en) begin
            lt_next = occupied && (key_reg < ctrl.key);
            eq_next = occupied && (key_reg == ctrl.key);
        end
    end

    always_comb begin
        key_next = key_reg;
        if (ctrl.ins_en) begin
            priority if (at_here) begin
                key_next = ctrl.key;
            end else if (!lt_reg) begin
                key_next = prev_key;
            end else begin
                // below the insert point: hold
                key_next = key_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign key_out = key_reg;
    assign lt_out  = lt_reg;
    assign eq_out  = eq_reg;

endmodule

// ----- rtl/sorted_unique_key_table.sv -----
// Sorted unique key table: a row of compare-and-shift cells with a small controller
//
// Input words (s_valid/s_ready/s_data) carry an action and a signed 64-bit key:
// insert, look up or clear. Each word yields exactly one result word on
// m_valid/m_ready/m_data with status, sorted position and the key count after it.
// Keys sit in ascending order, one per cell; every cell compares its key with
// the broadcast key at once, and on insert each cell above the insert point
// takes its lower neighbor's key while the new key drops into place.
// The result is registered in the output register after the word is accepted
// (held in the input register, compared in all cells, then decided and shifted).
// A new word is not taken while one is being compared: the compare cycle is followed
// by the shift cycle over the cell row, and the next word is captured in the shift cycle.
// Reset (aresetn low, synchronous) empties the table and drops all words in flight.
// When the receiver stalls, the result is held in the output register; one more
// word may be taken and compared, then s_ready stays low until the result drains.
module sorted_unique_key_table
    import suk_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  suk_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output suk_out_t m_data
);

`include "sorted_unique_key_table_defines.svh"

    logic             cmd_valid_reg;
    logic             cmd_valid_next;
    logic             dec_valid_reg;
    logic             dec_valid_next;
    logic [ACT_W-1:0] act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0] held_reg;
    logic [CNT_W-1:0] held_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    suk_out_t         m_data_reg;
    suk_out_t         m_data_next;

    logic             s_fire;
    logic             dec_fire;
    logic             cmp_en;
    logic             hit;
    logic             full;
    logic             ins_en;
    logic [IDX_W-1:0] pos;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0] pos_out;
    logic [IDX_W+POS_W-1:0]   pos_wide;
    logic [CNT_W+COUNT_W-1:0] cnt_wide;

    logic [DEPTH-1:0] lt_vec;
    logic [DEPTH-1:0] eq_vec;
    logic [DEPTH-1:0] at_vec;
    logic [DEPTH-1:0] occ_vec;
    logic [KEY_W-1:0] cell_key [DEPTH];
    suk_ctrl_t        ctrl;

    assign dec_fire = dec_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !cmd_valid_reg && (!dec_valid_reg || dec_fire);
    assign s_fire   = s_valid && s_ready;
    // Compare only once the previous shift has landed in the cells.
    assign cmp_en   = cmd_valid_reg && !dec_valid_reg;

    assign hit  = |eq_vec;
    assign full = (held_reg == CNT_W'(DEPTH));

    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (at_vec[i]) begin
                pos = pos | IDX_W'(i);
            end
        end
    end

    always_comb begin
        status    = ST_NOT_FOUND;
        pos_out   = '0;
        ins_en    = 1'b0;
        held_next = held_reg;
        unique case (act_reg)
            ACT_INSERT: begin
                priority if (hit) begin
                    status  = ST_DUPLICATE;
                    pos_out = pos;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    status    = ST_INSERTED;
                    pos_out   = pos;
                    ins_en    = dec_fire;
                    held_next = held_reg + CNT_W'(1);
                end
            end
            ACT_LOOKUP: begin
                if (hit) begin
                    status  = ST_FOUND;
                    pos_out = pos;
                end
            end
            ACT_CLEAR: begin
                status    = ST_INSERTED;
                held_next = '0;
            end
            default: begin
                status = ST_NOT_FOUND;
            end
        endcase
    end

    assign pos_wide = {{POS_W{1'b0}}, pos_out};
    assign cnt_wide = {{COUNT_W{1'b0}}, held_next};

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (dec_fire) begin
            m_valid_next         = 1'b1;
            m_data_next.status   = status;
            m_data_next.position = pos_wide[POS_W-1:0];
            m_data_next.count    = cnt_wide[COUNT_W-1:0];
        end
    end

    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        dec_valid_next = dec_valid_reg;
        if (cmp_en) begin
            cmd_valid_next = 1'b0;
            dec_valid_next = 1'b1;
        end
        if (dec_fire) begin
            dec_valid_next = 1'b0;
        end
        if (s_fire) begin
            cmd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            dec_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            held_reg      <= '0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
            dec_valid_reg <= dec_valid_next;
            m_valid_reg   <= m_valid_next;
            if (dec_fire) begin
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_fire) begin
            act_reg <= s_data.action;
            key_reg <= s_data.key ^ SIGN_FLIP;
        end
    end

    assign ctrl.cmp_en = cmp_en;
    assign ctrl.ins_en = ins_en;
    assign ctrl.key    = key_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic             prev_lt;
        logic [KEY_W-1:0] prev_key;

        assign occ_vec[i] = (CNT_W'(i) < held_reg);

        if (i == 0) begin : g_first
            assign prev_lt  = 1'b1;
            assign prev_key = key_reg;
        end else begin : g_rest
            assign prev_lt  = lt_vec[i-1];
            assign prev_key = cell_key[i-1];
        end

        suk_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .occupied (occ_vec[i]),
            .prev_lt  (prev_lt),
            .prev_key (prev_key),
            .key_out  (cell_key[i]),
            .lt_out   (lt_vec[i]),
            .eq_out   (eq_vec[i]),
            .at_here  (at_vec[i])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SUK_ASSERT_ALWAYS(a_held_bound, held_reg <= CNT_W'(DEPTH), "key count above table depth")
    `SUK_ASSERT_ALWAYS(a_one_stage, !(cmd_valid_reg && dec_valid_reg), "two words in the cell row")
    `SUK_ASSERT_SAME(a_one_slot, dec_valid_reg, $onehot0(at_vec), "insert point not unique")
    `SUK_ASSERT_NEXT(a_clear, dec_fire && act_reg == ACT_CLEAR, held_reg == '0, "clear left keys")

endmodule
